// ===== hw/rtl/md5bc_pkg.sv =====
// ----------------------------------------------------------------------------
// md5bc_pkg
// Types, constants and step tables for the md5 block compression unit.
// ----------------------------------------------------------------------------
package md5bc_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned Steps  = 64;
  localparam int unsigned BufLen = 16;
  localparam int unsigned StepW  = $clog2(Steps);
  localparam int unsigned IdxW   = $clog2(BufLen);

  // input word: one message word plus the restart flag
  typedef struct packed {
    logic [WordW-1:0] msg_word;
    logic             restart;
  } in_t;

  // result word: chaining value after a block
  typedef struct packed {
    logic [WordW-1:0] digest_a;
    logic [WordW-1:0] digest_b;
    logic [WordW-1:0] digest_c;
    logic [WordW-1:0] digest_d;
  } out_t;

  // initial chaining value
  localparam logic [WordW-1:0] IvA = 32'h67452301;
  localparam logic [WordW-1:0] IvB = 32'hefcdab89;
  localparam logic [WordW-1:0] IvC = 32'h98badcfe;
  localparam logic [WordW-1:0] IvD = 32'h10325476;

  // round codes
  localparam logic [1:0] RndF = 2'd0;
  localparam logic [1:0] RndG = 2'd1;
  localparam logic [1:0] RndH = 2'd2;
  localparam logic [1:0] RndI = 2'd3;

  // additive constants, one per step
  localparam logic [WordW-1:0] StepConst [Steps] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // rotate amount for a step, from its round and position within four
  function automatic logic [4:0] rot_amt(logic [1:0] rnd, logic [1:0] pos);
    logic [4:0] amt;
    amt = 5'd0;
    unique case (rnd)
      RndF: begin
        unique case (pos)
          2'd0: amt = 5'd7;
          2'd1: amt = 5'd12;
          2'd2: amt = 5'd17;
          default: amt = 5'd22;
        endcase
      end
      RndG: begin
        unique case (pos)
          2'd0: amt = 5'd5;
          2'd1: amt = 5'd9;
          2'd2: amt = 5'd14;
          default: amt = 5'd20;
        endcase
      end
      RndH: begin
        unique case (pos)
          2'd0: amt = 5'd4;
          2'd1: amt = 5'd11;
          2'd2: amt = 5'd16;
          default: amt = 5'd23;
        endcase
      end
      default: begin
        unique case (pos)
          2'd0: amt = 5'd6;
          2'd1: amt = 5'd10;
          2'd2: amt = 5'd15;
          default: amt = 5'd21;
        endcase
      end
    endcase
    return amt;
  endfunction

  // buffer index of the message word used by a step
  function automatic logic [IdxW-1:0] word_idx(logic [StepW-1:0] step);
    logic [IdxW-1:0] i;
    logic [IdxW-1:0] idx;
    i   = step[IdxW-1:0];
    idx = i;
    unique case (step[StepW-1:StepW-2])
      RndF: idx = i;
      RndG: idx = IdxW'(i * 4'd5 + 4'd1);
      RndH: idx = IdxW'(i * 4'd3 + 4'd5);
      default: idx = IdxW'(i * 4'd7);
    endcase
    return idx;
  endfunction

  // round mixing function
  function automatic logic [WordW-1:0] mix(logic [1:0] rnd, logic [WordW-1:0] x,
                                           logic [WordW-1:0] y, logic [WordW-1:0] z);
    logic [WordW-1:0] f;
    f = '0;
    unique case (rnd)
      RndF: f = (x & y) | (~x & z);
      RndG: f = (x & z) | (y & ~z);
      RndH: f = x ^ y ^ z;
      default: f = y ^ (x | ~z);
    endcase
    return f;
  endfunction

endpackage

// ===== hw/rtl/md5_block_compression.sv =====
// ----------------------------------------------------------------------------
// md5_block_compression
// Buffers 16 message words, runs the 64-step md5 compression over them and
// returns the updated chaining value.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  in      | input     | in_valid_i / in_ready_o    | in_data_i  (msg_word, restart)
//  out     | output    | out_valid_o / out_ready_i  | out_data_o (digest_a..d)
//
//  One word is taken per cycle while the unit is collecting a block.
//  The 16th word starts 64 compression steps, one per cycle, set by the
//  single step datapath fed from the message buffer read port; the finish
//  state then adds the chaining value.
//  The finish cycle waits while the previous result is still untaken.
//  Reset loads the standard initial chaining value; the buffer needs no clear.
// ----------------------------------------------------------------------------
module md5_block_compression (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  md5bc_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output md5bc_pkg::out_t out_data_o
);
  import md5bc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [IdxW-1:0]  cnt_q, cnt_d;
  logic [StepW-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_data_q;

  logic [WordW-1:0] chain_q [4];
  logic [WordW-1:0] work_q  [4];

  // message buffer, one write and one registered read port
  logic [WordW-1:0] msg_mem [BufLen];
  logic [WordW-1:0] rd_data_q;
  logic             mem_we, mem_re;
  logic [IdxW-1:0]  wr_addr, rd_addr;

  logic             in_fire, out_fire, fin_go, last_word;
  logic [WordW-1:0] f_val, t_sum, rot_val, new_b;
  logic [2*WordW-1:0] rot_wide;
  logic [StepW-1:0] step_nxt;
  logic [WordW-1:0] sum [4];

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_q && out_ready_i;
  assign fin_go      = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
  assign wr_addr     = in_data_i.restart ? '0 : cnt_q;
  assign last_word   = (wr_addr == IdxW'(BufLen - 1));
  assign step_nxt    = step_q + StepW'(1);

  // buffer write on accepted words, read one step ahead of the datapath
  assign mem_we  = in_fire;
  assign mem_re  = (in_fire && last_word) || (state_q == S_RUN);
  assign rd_addr = (state_q == S_RUN) ? word_idx(step_nxt) : word_idx('0);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      msg_mem[wr_addr] <= in_data_i.msg_word;
    end
    if (mem_re) begin
      rd_data_q <= msg_mem[rd_addr];
    end
  end

  // one compression step
  always_comb begin
    f_val    = mix(step_q[StepW-1:StepW-2], work_q[1], work_q[2], work_q[3]);
    t_sum    = work_q[0] + f_val + rd_data_q + StepConst[step_q];
    rot_wide = {t_sum, t_sum} << rot_amt(step_q[StepW-1:StepW-2], step_q[1:0]);
    rot_val  = rot_wide[2*WordW-1:WordW];
    new_b    = work_q[1] + rot_val;
  end

  // final feed-forward of the working words
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum[k] = chain_q[k] + work_q[k];
    end
  end

  // control sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (out_fire) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (last_word) begin
            cnt_d   = '0;
            step_d  = '0;
            state_d = S_RUN;
          end else begin
            cnt_d = wr_addr + IdxW'(1);
          end
        end
      end
      S_RUN: begin
        step_d = step_nxt;
        if (step_q == StepW'(Steps - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // chaining value: reload on restart, accumulate at block end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q[0] <= IvA;
      chain_q[1] <= IvB;
      chain_q[2] <= IvC;
      chain_q[3] <= IvD;
    end else if (in_fire && in_data_i.restart) begin
      chain_q[0] <= IvA;
      chain_q[1] <= IvB;
      chain_q[2] <= IvC;
      chain_q[3] <= IvD;
    end else if (fin_go) begin
      for (int k = 0; k < 4; k++) begin
        chain_q[k] <= sum[k];
      end
    end
  end

  // working words and result register
  always_ff @(posedge clk_i) begin
    if (in_fire && last_word) begin
      for (int k = 0; k < 4; k++) begin
        work_q[k] <= chain_q[k];
      end
    end else if (state_q == S_RUN) begin
      work_q[0] <= work_q[3];
      work_q[1] <= new_b;
      work_q[2] <= work_q[1];
      work_q[3] <= work_q[2];
    end
    if (fin_go) begin
      out_data_q.digest_a <= sum[0];
      out_data_q.digest_b <= sum[1];
      out_data_q.digest_c <= sum[2];
      out_data_q.digest_d <= sum[3];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
